// ----- rtl/core/wps_pkg.sv -----
// Shared types and constants for the WAV PCM16 stream parser.
package wps_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
  localparam logic [15:0] PCM_CODE       = 16'd1;
  localparam logic [15:0] MONO_CHANNELS  = 16'd1;
  localparam logic [15:0] SAMPLE_BITS    = 16'd16;

  localparam int unsigned RATE_W = 19;
  localparam logic [RATE_W-1:0] RATE_RESET = 19'd16000;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] ERR_TAG    = 2'd0;
  localparam logic [1:0] ERR_FORMAT = 2'd1;
  localparam logic [1:0] ERR_DATA   = 2'd2;
  localparam logic [1:0] ERR_TRUNC  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample;
    logic [1:0]         error_code;
    logic               last_sample;
  } result_t;

endpackage

// ----- rtl/core/wav_pcm16_stream_parser.sv -----
// A byte beat passes through the byte queue, and the result beat it causes is registered.
// Throughput: one byte beat per cycle, set by the chunk walker step, while the result output is not stalled.
// A two-entry byte queue feeds the walker, and a result register drives the output.
// Reset is synchronous: the walker returns to the RIFF header, the queue empties,
// and the expected sample rate returns to 16000 Hz.
module wav_pcm16_stream_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wps_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  wps_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output wps_pkg::result_t           result
);
  import wps_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  wps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  wps_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/core/wps_queue.sv -----
// Two-entry input queue that decouples byte acceptance from parsing.
module wps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  wps_pkg::item_t item,
  output logic           q_valid,
  input  logic           q_pop,
  output wps_pkg::item_t q_item
);
  import wps_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item_ready = (count != 2'd2);
  assign q_valid    = (count != 2'd0);
  assign q_item     = mem[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/wps_parser.sv -----
// Chunk walker that turns queued bytes into samples and status results.
module wps_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wps_pkg::RATE_W-1:0]    cfg_wdata,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  wps_pkg::item_t                q_item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output wps_pkg::result_t              result
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        byte_index, byte_index_next;
  logic [31:0]       tag_shift, tag_shift_next;
  logic [31:0]       field_shift, field_shift_next;
  logic [31:0]       chunk_remaining, chunk_remaining_next;
  logic              chunk_is_odd, chunk_is_odd_next;
  logic              format_seen, format_seen_next;
  logic [7:0]        low_byte, low_byte_next;
  logic [RATE_W-1:0] expected_rate;

  logic        step;
  logic        emit;
  logic        finished;
  result_t     res;
  logic [31:0] tag_in;
  logic [31:0] field_in;
  logic [31:0] rem_dec;

  assign step   = q_valid && (!result_valid || result_ready);
  assign q_pop  = step;
  assign tag_in   = {q_item.data_byte, tag_shift[31:8]};
  assign field_in = {q_item.data_byte, field_shift[31:8]};
  assign rem_dec  = chunk_remaining - 32'd1;

  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    tag_shift_next       = tag_shift;
    field_shift_next     = field_shift;
    chunk_remaining_next = chunk_remaining;
    chunk_is_odd_next    = chunk_is_odd;
    format_seen_next     = format_seen;
    low_byte_next        = low_byte;
    emit                 = 1'b0;
    finished             = 1'b0;
    res                  = '0;

    unique case (phase)
      PH_HEADER: begin
        tag_shift_next = tag_in;
        if ((byte_index == 4'd3 && tag_in != TAG_RIFF) ||
            (byte_index == 4'd11 && tag_in != TAG_WAVE)) begin
          finished       = 1'b1;
          emit           = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code  = ERR_TAG;
          phase_next     = PH_ERROR;
        end else if (byte_index >= 4'd11) begin
          phase_next      = PH_CHUNK;
          byte_index_next = 4'd0;
        end else begin
          byte_index_next = byte_index + 4'd1;
        end
      end
      PH_CHUNK: begin
        if (byte_index < 4'd4) begin
          tag_shift_next = tag_in;
        end else begin
          field_shift_next = field_in;
        end
        if (byte_index < 4'd7) begin
          byte_index_next = byte_index + 4'd1;
        end else begin
          byte_index_next   = 4'd0;
          chunk_is_odd_next = field_in[0];
          if (tag_shift == TAG_FMT) begin
            if (field_in < FMT_CORE_BYTES) begin
              finished        = 1'b1;
              emit            = 1'b1;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_FORMAT;
              phase_next      = PH_ERROR;
            end else begin
              chunk_remaining_next = field_in - FMT_CORE_BYTES;
              phase_next           = PH_FMT;
            end
          end else if (tag_shift == TAG_DATA) begin
            if (!format_seen || field_in[0]) begin
              finished        = 1'b1;
              emit            = 1'b1;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_DATA;
              phase_next      = PH_ERROR;
            end else if (field_in == 32'd0) begin
              finished        = 1'b1;
              emit            = 1'b1;
              res.result_kind = KIND_EMPTY;
              phase_next      = PH_DONE;
            end else begin
              chunk_remaining_next = field_in;
              phase_next           = PH_DATA;
            end
          end else begin
            chunk_remaining_next = field_in;
            if (field_in == 32'd0) begin
              phase_next = PH_CHUNK;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        field_shift_next = field_in;
        if ((byte_index == 4'd1 && field_in[31:16] != PCM_CODE) ||
            (byte_index == 4'd3 && field_in[31:16] != MONO_CHANNELS) ||
            (byte_index == 4'd7 && field_in != {13'd0, expected_rate}) ||
            (byte_index == 4'd15 && field_in[31:16] != SAMPLE_BITS)) begin
          finished        = 1'b1;
          emit            = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code  = ERR_FORMAT;
          phase_next      = PH_ERROR;
        end else if (byte_index == 4'd15) begin
          format_seen_next = 1'b1;
          byte_index_next  = 4'd0;
          if (chunk_remaining == 32'd0 && !chunk_is_odd) begin
            phase_next = PH_CHUNK;
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          byte_index_next = byte_index + 4'd1;
        end
      end
      PH_SKIP: begin
        if (chunk_remaining != 32'd0) begin
          chunk_remaining_next = rem_dec;
          if (rem_dec == 32'd0 && !chunk_is_odd) begin
            phase_next      = PH_CHUNK;
            byte_index_next = 4'd0;
          end
        end else begin
          chunk_is_odd_next = 1'b0;
          phase_next        = PH_CHUNK;
          byte_index_next   = 4'd0;
        end
      end
      PH_DATA: begin
        chunk_remaining_next = rem_dec;
        if (!byte_index[0]) begin
          low_byte_next   = q_item.data_byte;
          byte_index_next = 4'd1;
        end else begin
          byte_index_next = 4'd0;
          res.sample      = {q_item.data_byte, low_byte};
          if (rem_dec == 32'd0) begin
            finished        = 1'b1;
            emit            = 1'b1;
            res.last_sample = 1'b1;
            phase_next      = PH_DONE;
          end else if (!q_item.end_of_stream) begin
            finished = 1'b1;
            emit     = 1'b1;
          end
        end
      end
      PH_DONE, PH_ERROR: begin
        finished = 1'b1;
      end
      default: begin
        finished   = 1'b1;
        phase_next = PH_ERROR;
      end
    endcase

    if (!finished && q_item.end_of_stream) begin
      emit            = 1'b1;
      res             = '0;
      res.result_kind = KIND_ERROR;
      res.error_code  = ERR_TRUNC;
      phase_next      = PH_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate <= RATE_RESET;
    end else if (cfg_we) begin
      expected_rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_index      <= 4'd0;
      tag_shift       <= '0;
      field_shift     <= '0;
      chunk_remaining <= '0;
      chunk_is_odd    <= 1'b0;
      format_seen     <= 1'b0;
      low_byte        <= '0;
      result_valid    <= 1'b0;
      result          <= '0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        byte_index      <= byte_index_next;
        tag_shift       <= tag_shift_next;
        field_shift     <= field_shift_next;
        chunk_remaining <= chunk_remaining_next;
        chunk_is_odd    <= chunk_is_odd_next;
        format_seen     <= format_seen_next;
        low_byte        <= low_byte_next;
      end
      if (step && emit) begin
        result_valid <= 1'b1;
        result       <= res;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
